// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	localparam int MAP_BITS_DEF = 8192;
	localparam int INDEX_W      = 13;
	localparam int COUNT_W      = 14;
	localparam int COUNT_RST    = 8192;
	localparam int MAP_WORD_W   = 32;
	localparam int BIT_SEL_W    = 5;
	localparam int Q_DEPTH      = 2;

	typedef enum logic [1:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_IGNORE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [INDEX_W-1:0] index;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_SCAN,
		B_FREE_RD,
		B_FREE_WR,
		B_RESP
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front
// Holds block_count, derives the active limit and classifies request words.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_front import bba_pkg::*; #(
	parameter int MAP_BITS = MAP_BITS_DEF,
	parameter int LIM_W    = $clog2(MAP_BITS + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               block_count_we,
	input  wire logic [COUNT_W-1:0] block_count,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               operation,
	input  wire logic [INDEX_W-1:0] block_index,
	input  wire logic               q_full,
	input  wire logic               clear_busy,
	output logic                    push,
	output cmd_t                    push_cmd,
	output logic [LIM_W-1:0]        lim
);

	logic [COUNT_W-1:0] block_count_q;
	logic [31:0]        lim_wide;
	logic               idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= COUNT_W'(COUNT_RST);
		end else if (block_count_we) begin
			block_count_q <= block_count;
		end
	end

	assign lim_wide = (32'(block_count_q) > 32'(MAP_BITS)) ? 32'(MAP_BITS)
	                                                       : 32'(block_count_q);
	assign lim      = lim_wide[LIM_W-1:0];

	assign idx_ok    = (block_index != '0) && (32'(block_index) < lim_wide);
	assign req_stall = q_full || clear_busy;
	assign push      = req_valid && !req_stall;

	always_comb begin
		push_cmd.index = block_index;
		if (!operation) begin
			push_cmd.kind = CMD_ALLOC;
		end else if (idx_ok) begin
			push_cmd.kind = CMD_FREE;
		end else begin
			push_cmd.kind = CMD_IGNORE;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bba_queue.sv
// ----------------------------------------------------------------------------
// bba_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_queue import bba_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_chan_t head
);

	cmd_t       slot_q [Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'(Q_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back
// Bitmap memory, clearing pass, first-fit scan, free and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_back import bba_pkg::*; #(
	parameter int MAP_BITS  = MAP_BITS_DEF,
	parameter int LIM_W     = $clog2(MAP_BITS + 1),
	parameter int MAP_WORDS = (MAP_BITS + MAP_WORD_W - 1) / MAP_WORD_W,
	parameter int AW        = $clog2(MAP_WORDS)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [LIM_W-1:0]   lim,
	input  wire cmd_chan_t          head,
	output logic                    pop,
	output logic                    clear_busy,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [INDEX_W-1:0]      granted_index,
	output logic                    success
);

	logic [MAP_WORD_W-1:0] mem_q [MAP_WORDS];
	logic [MAP_WORD_W-1:0] rdata_q;

	back_state_t           state_q, state_d;
	logic [AW-1:0]         clr_addr_q;
	logic [AW:0]           rd_addr_q;
	logic [AW-1:0]         chk_addr_s1;
	logic                  chk_vld_s1;
	logic [AW-1:0]         free_addr_q;
	logic [BIT_SEL_W-1:0]  free_bit_q;
	logic [INDEX_W-1:0]    res_granted_q;
	logic                  res_ok_q;
	logic                  out_valid_q;
	logic [INDEX_W-1:0]    out_granted_q;
	logic                  out_ok_q;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [MAP_WORD_W-1:0] wr_data;

	logic [31:0]           nw_wide;
	logic [AW:0]           nwords;
	logic [BIT_SEL_W-1:0]  tail;
	logic                  is_last;
	logic [MAP_WORD_W-1:0] valid_mask;
	logic [MAP_WORD_W-1:0] free_bits;
	logic [MAP_WORD_W-1:0] low_bit;
	logic [BIT_SEL_W-1:0]  bit_pos;
	logic                  found;
	logic [31:0]           grant_wide;
	logic [31:0]           free_word_wide;
	logic                  out_free;
	logic                  out_load;
	logic                  res_set;
	logic [INDEX_W-1:0]    res_granted_d;
	logic                  res_ok_d;
	logic                  scan_start;
	logic                  free_start;

	assign nw_wide = (32'(lim) + 32'(MAP_WORD_W - 1)) >> BIT_SEL_W;
	assign nwords  = nw_wide[AW:0];
	assign tail    = lim[BIT_SEL_W-1:0];
	assign is_last = ((AW+1)'(chk_addr_s1) + (AW+1)'(1)) == nwords;

	assign valid_mask = (is_last && (tail != '0)) ? ((MAP_WORD_W'(1) << tail) - MAP_WORD_W'(1))
	                                              : '1;
	assign free_bits  = ~rdata_q & valid_mask;
	assign low_bit    = free_bits & (~free_bits + MAP_WORD_W'(1));
	assign found      = chk_vld_s1 && (free_bits != '0);

	always_comb begin
		bit_pos = '0;
		for (int b = 0; b < MAP_WORD_W; b++) begin
			if (low_bit[b]) begin
				bit_pos = bit_pos | BIT_SEL_W'(b);
			end
		end
	end

	assign grant_wide     = (32'(chk_addr_s1) << BIT_SEL_W) | 32'(bit_pos);
	assign free_word_wide = 32'(head.cmd.index) >> BIT_SEL_W;

	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d       = state_q;
		pop           = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = rd_addr_q[AW-1:0];
		wr_en         = 1'b0;
		wr_addr       = chk_addr_s1;
		wr_data       = rdata_q | low_bit;
		res_set       = 1'b0;
		res_granted_d = '0;
		res_ok_d      = 1'b0;
		out_load      = 1'b0;
		scan_start    = 1'b0;
		free_start    = 1'b0;
		case (state_q)
			B_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = (clr_addr_q == '0) ? MAP_WORD_W'(1) : '0;
				if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					case (head.cmd.kind)
						CMD_ALLOC: begin
							if (nwords == '0) begin
								res_set = 1'b1;
								state_d = B_RESP;
							end else begin
								scan_start = 1'b1;
								state_d    = B_SCAN;
							end
						end
						CMD_FREE: begin
							free_start = 1'b1;
							state_d    = B_FREE_RD;
						end
						default: begin
							res_set = 1'b1;
							state_d = B_RESP;
						end
					endcase
				end
			end
			B_SCAN: begin
				rd_en = (rd_addr_q < nwords) && !found;
				if (found) begin
					wr_en         = 1'b1;
					res_set       = 1'b1;
					res_granted_d = grant_wide[INDEX_W-1:0];
					res_ok_d      = 1'b1;
					state_d       = B_RESP;
				end else if (chk_vld_s1 && is_last) begin
					res_set = 1'b1;
					state_d = B_RESP;
				end
			end
			B_FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = free_addr_q;
				state_d = B_FREE_WR;
			end
			B_FREE_WR: begin
				wr_en    = 1'b1;
				wr_addr  = free_addr_q;
				wr_data  = rdata_q & ~(MAP_WORD_W'(1) << free_bit_q);
				res_set  = 1'b1;
				res_ok_d = 1'b1;
				state_d  = B_RESP;
			end
			B_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			rd_addr_q   <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (scan_start) begin
				rd_addr_q <= '0;
			end else if (rd_en && (state_q == B_SCAN)) begin
				rd_addr_q <= rd_addr_q + (AW+1)'(1);
			end
			chk_vld_s1 <= rd_en && (state_q == B_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_s1 <= rd_addr_q[AW-1:0];
		if (free_start) begin
			free_addr_q <= free_word_wide[AW-1:0];
			free_bit_q  <= head.cmd.index[BIT_SEL_W-1:0];
		end
		if (res_set) begin
			res_granted_q <= res_granted_d;
			res_ok_q      <= res_ok_d;
		end
		if (out_load) begin
			out_granted_q <= res_granted_q;
			out_ok_q      <= res_ok_q;
		end
	end

	assign clear_busy    = (state_q == B_CLEAR);
	assign rsp_valid     = out_valid_q;
	assign granted_index = out_granted_q;
	assign success       = out_ok_q;

	a_reserved_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (wr_addr == '0)) |-> wr_data[0])
		else $error("reserved block 0 cleared");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && (state_q == B_SCAN)) |-> (rd_addr_q < nwords))
		else $error("scan read beyond limit");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE))
		else $error("command popped while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ok_q) |-> (out_granted_q == '0))
		else $error("failed result with non-zero index");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !rsp_stall))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: rtl/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit bitmap allocator: front classifies, queue decouples, back works
// on the bitmap memory.
// ----------------------------------------------------------------------------
//  channel   | handshake              | word
//  ----------+------------------------+------------------------------------
//  request   | req_valid / req_stall  | operation, block_index
//  response  | rsp_valid / rsp_stall  | granted_index, success
//  config    | block_count_we         | block_count
//
//  Allocate: the scan reads one map word per cycle from the single-port bitmap
//  memory, over nwords = ceil(limit / 32) words; a stalled result holds the back
//  until taken.
//  After reset a clearing pass over MAP_BITS/32 map words runs; req_stall is high.
//  A two-word queue takes requests while a result waits under rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator_unit import bba_pkg::*; #(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               block_count_we,
	input  wire logic [COUNT_W-1:0] block_count,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               operation,
	input  wire logic [INDEX_W-1:0] block_index,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [INDEX_W-1:0]      granted_index,
	output logic                    success
);

	localparam int LIM_W = $clog2(MAP_BITS + 1);

	logic             q_full;
	logic             clear_busy;
	logic             push;
	cmd_t             push_cmd;
	logic [LIM_W-1:0] lim;
	logic             pop;
	cmd_chan_t        head;

	bba_front #(
		.MAP_BITS (MAP_BITS),
		.LIM_W    (LIM_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.block_count_we (block_count_we),
		.block_count    (block_count),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.operation      (operation),
		.block_index    (block_index),
		.q_full         (q_full),
		.clear_busy     (clear_busy),
		.push           (push),
		.push_cmd       (push_cmd),
		.lim            (lim)
	);

	bba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	bba_back #(
		.MAP_BITS (MAP_BITS),
		.LIM_W    (LIM_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.lim           (lim),
		.head          (head),
		.pop           (pop),
		.clear_busy    (clear_busy),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.granted_index (granted_index),
		.success       (success)
	);

endmodule

`default_nettype wire

// File: tb/tb_block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_block_bitmap_allocator_unit
// Self-checking bench for the first-fit block bitmap allocator. A shadow
// bitmap predicts each response word at request acceptance; responses are
// checked in order, across several block counts with random idling and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_block_bitmap_allocator_unit;
	import bba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] idx;
	} alloc_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               ok;
	} grant_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               block_count_we = 1'b0;
	logic [COUNT_W-1:0] block_count    = '0;
	logic               req_valid      = 1'b0;
	logic               req_stall;
	logic               operation      = OP_ALLOC;
	logic [INDEX_W-1:0] block_index    = '0;
	logic               rsp_valid;
	logic               rsp_stall      = 1'b0;
	logic [INDEX_W-1:0] granted_index;
	logic               success;

	alloc_req_t pending_reqs[$];
	grant_t     owed_grants[$];
	logic       req_taken      = 1'b0;
	logic       steady         = 1'b0;
	int         mismatch_count = 0;

	logic [MAP_BITS_DEF-1:0] shadow_map   = 1;
	int unsigned             shadow_count = COUNT_RST;

	block_bitmap_allocator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.block_count_we(block_count_we),
		.block_count   (block_count),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.block_index   (block_index),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.granted_index (granted_index),
		.success       (success)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned active_limit();
		return (shadow_count > MAP_BITS_DEF) ? MAP_BITS_DEF : shadow_count;
	endfunction

	function automatic grant_t first_fit_step(logic op, logic [INDEX_W-1:0] idx);
		grant_t      r;
		int unsigned lim;
		r   = '0;
		lim = active_limit();
		if (op == OP_ALLOC) begin
			for (int unsigned i = 0; i < lim; i++) begin
				if (!shadow_map[i]) begin
					shadow_map[i] = 1'b1;
					r.index       = i[INDEX_W-1:0];
					r.ok          = 1'b1;
					break;
				end
			end
		end else if (idx != 0 && idx < lim) begin
			shadow_map[idx] = 1'b0;
			r.ok            = 1'b1;
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// driver: new word at the falling edge, held while stalled
	always @(negedge clk) begin
		alloc_req_t w;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_taken) begin
		end else if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
			w = pending_reqs.pop_front();
			req_valid   <= 1'b1;
			operation   <= w.op;
			block_index <= w.idx;
		end else begin
			req_valid <= 1'b0;
		end
		rsp_stall <= !steady && ($urandom_range(99) < 30);
	end

	// monitor: predict on request acceptance, check on response acceptance
	always @(posedge clk) begin
		grant_t want;
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall)
				owed_grants.push_back(first_fit_step(operation, block_index));
			if (rsp_valid && !rsp_stall) begin
				if (owed_grants.size() == 0) begin
					flag_mismatch("unexpected word, granted_index", granted_index, 0);
				end else begin
					want = owed_grants.pop_front();
					if (granted_index !== want.index)
						flag_mismatch("granted_index", granted_index, want.index);
					if (success !== want.ok)
						flag_mismatch("success", success, want.ok);
				end
			end
		end
	end

	task automatic push_req(logic op, int idx);
		pending_reqs.push_back('{op: op, idx: idx[INDEX_W-1:0]});
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_valid || owed_grants.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_block_count(int v);
		drain();
		block_count_we <= 1'b1;
		block_count    <= v[COUNT_W-1:0];
		shadow_count    = v[COUNT_W-1:0];
		@(negedge clk);
		block_count_we <= 1'b0;
	endtask

	function automatic int pick_free_index();
		int unsigned lim;
		int          r;
		lim = active_limit();
		r   = $urandom_range(99);
		if (r < 10)
			return 0;
		if (r < 25 || lim < 2)
			return $urandom_range(2**INDEX_W - 1);
		if (r < 30)
			return lim;
		return $urandom_range(lim - 1, 1);
	endfunction

	task automatic queue_allocs(int n);
		for (int i = 0; i < n; i++)
			push_req(OP_ALLOC, $urandom_range(2**INDEX_W - 1));
	endtask

	task automatic queue_mix(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 55)
				push_req(OP_ALLOC, $urandom_range(2**INDEX_W - 1));
			else
				push_req(OP_FREE, pick_free_index());
		end
	endtask

	// one random phase: fill burst, full pause, then a mixed run
	task automatic run_phase(int count, int burst, int mixed, logic calm);
		write_block_count(count);
		queue_allocs(burst);
		drain();
		steady = calm;
		queue_mix(mixed);
		drain();
		steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset count: lowest grants, reserved index, double free, extreme indices
		push_req(OP_ALLOC, 13'h1FFF);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 0);
		push_req(OP_FREE, 1);
		push_req(OP_FREE, 1);
		push_req(OP_ALLOC, 13'h0AAA);
		push_req(OP_FREE, 13'h1FFF);
		push_req(OP_FREE, 13'h1555);
		push_req(OP_FREE, 13'h0AAA);
		push_req(OP_FREE, 2);

		// zero count: nothing granted, every free ignored
		write_block_count(0);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 5);
		push_req(OP_FREE, 0);

		// only the reserved entry in range
		write_block_count(1);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 0);
		push_req(OP_FREE, 1);

		write_block_count(2);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 1);
		push_req(OP_ALLOC, 0);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 2);

		// count above map size saturates
		write_block_count(2**COUNT_W - 1);
		push_req(OP_ALLOC, 0);
		push_req(OP_FREE, 13'h1FFF);
		push_req(OP_FREE, 13'h1FFE);

		run_phase(40, 43, 120, 1'b0);
		run_phase(3, 6, 40, 1'b0);
		run_phase(COUNT_RST, 0, 60, 1'b0);
		run_phase(2**COUNT_W - 1, 0, 50, 1'b0);
		run_phase(100, 103, 150, 1'b1);
		run_phase(COUNT_RST + 1, 0, 40, 1'b0);
		run_phase(1, 3, 20, 1'b0);
		run_phase(0, 3, 20, 1'b0);
		run_phase(300, 0, 150, 1'b0);
		run_phase(64, 70, 80, 1'b0);

		drain();
		repeat (300) @(posedge clk);
		if (owed_grants.size() != 0)
			flag_mismatch("words never returned", 0, owed_grants.size());
		if (mismatch_count == 0)
			$display("PASS block_bitmap_allocator_unit");
		else
			$display("FAIL block_bitmap_allocator_unit");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL block_bitmap_allocator_unit");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
rtl/bba_pkg.sv
rtl/bba_front.sv
rtl/bba_queue.sv
rtl/bba_back.sv
rtl/block_bitmap_allocator_unit.sv
tb/tb_block_bitmap_allocator_unit.sv
